// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL; bodies compile away when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- sv/wis_pkg.sv -----
// Widths, codes and register indexes of the weighted index sampler.
package wis_pkg;

    localparam int ENTRY_BITS  = 10;
    localparam int MAX_ENTRIES = 1 << ENTRY_BITS;
    localparam int CNT_BITS    = ENTRY_BITS + 1;   // holds 0..MAX_ENTRIES
    localparam int WEIGHT_BITS = 16;
    localparam int RANDOM_BITS = 16;
    localparam int SUM_BITS    = WEIGHT_BITS + ENTRY_BITS;
    localparam int PROD_BITS   = SUM_BITS + RANDOM_BITS;
    localparam int PICK_BITS   = 11;
    localparam logic [PICK_BITS-1:0] PICK_MAX = {PICK_BITS{1'b1}};

    // configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PICK_TARGET  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALLOW_REPEAT = 1'd1;
    localparam int CFG_DATA_BITS = PICK_BITS;

    // request codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DRAW = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_STORED   = 2'd0;
    localparam logic [1:0] STAT_ACCEPTED = 2'd1;
    localparam logic [1:0] STAT_REJECTED = 2'd2;
    localparam logic [1:0] STAT_IGNORED  = 2'd3;

endpackage

// ----- sv/wis_ram.sv -----
// Simple dual-port RAM: one write port, one registered read port.
module wis_ram #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0] o_rd_data
);

    logic [DATA_BITS-1:0] r_mem [(1 << ADDR_BITS)];
    logic [DATA_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/weighted_index_sampler.sv -----
// Top level of the weighted index sampler: loads weights, draws indexes by binary search.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_func i_weight i_last_weight i_random_value
//  out     | output    | o_out_valid / i_out_ready | o_index o_status o_pick_count o_picks_done
//          |           |                           | o_finished
//  cfg     | input     | i_cfg_wr_en (no wait)     | i_cfg_index i_cfg_data
//
// One word at a time. A load goes through accept, store and output. A draw
// that proceeds also runs the binary search over the n loaded entries, one
// prefix-sum RAM read and one compare per cycle, and a pick-count update;
// an ignored draw takes the same path as a load.
// Reset (i_rst_n low, synchronous) clears the control state and the registers
// to pick_target = 1, allow_repeat = 0; RAM contents are not cleared and only
// entries of the current set are ever read.
// A stalled output holds the finished word; the next input word is taken as
// soon as the sequencer is back in idle, while the result may still wait.
`include "assert_macros.svh"

module weighted_index_sampler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input words
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_func,
    input  logic [wis_pkg::WEIGHT_BITS-1:0]     i_weight,
    input  logic                                i_last_weight,
    input  logic [wis_pkg::RANDOM_BITS-1:0]     i_random_value,
    // result words
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [wis_pkg::ENTRY_BITS-1:0]      o_index,
    output logic [1:0]                          o_status,
    output logic [wis_pkg::PICK_BITS-1:0]       o_pick_count,
    output logic [wis_pkg::PICK_BITS-1:0]       o_picks_done,
    output logic                                o_finished,
    // configuration writes
    input  logic                                i_cfg_wr_en,
    input  logic [wis_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [wis_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    import wis_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,   // waiting for a word
        S_DEC  = 5'b00010,   // load store, or draw setup (product, first probe)
        S_SRCH = 5'b00100,   // one binary search step per cycle
        S_CNT  = 5'b01000,   // pick count read back, update
        S_DONE = 5'b10000    // hand result to output register
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [PICK_BITS-1:0]   r_target;
    logic                   r_allow_rep;

    // set bookkeeping
    logic [CNT_BITS-1:0]    r_loaded,   n_loaded;
    logic [SUM_BITS-1:0]    r_total,    n_total;
    logic [PICK_BITS-1:0]   r_accepted, n_accepted;
    logic                   r_closed,   n_closed;

    // captured input word
    logic                   r_func;
    logic [WEIGHT_BITS-1:0] r_weight;
    logic                   r_last;
    logic [RANDOM_BITS-1:0] r_rand;

    // search state
    logic [PROD_BITS-1:0]   r_prod;
    logic [CNT_BITS-1:0]    r_lo, r_hi;
    logic [ENTRY_BITS-1:0]  r_mid;

    // pending result
    logic [ENTRY_BITS-1:0]  r_res_index, n_res_index;
    logic [1:0]             r_res_status, n_res_status;
    logic [PICK_BITS-1:0]   r_res_count, n_res_count;

    // output register
    logic                   r_out_valid;
    logic [ENTRY_BITS-1:0]  r_out_index;
    logic [1:0]             r_out_status;
    logic [PICK_BITS-1:0]   r_out_count;
    logic [PICK_BITS-1:0]   r_out_done;
    logic                   r_out_fin;

    // RAM ports
    logic                   w_pfx_we;
    logic [ENTRY_BITS-1:0]  w_pfx_waddr;
    logic [SUM_BITS-1:0]    w_pfx_wdata;
    logic [ENTRY_BITS-1:0]  w_pfx_raddr;
    logic [SUM_BITS-1:0]    w_pfx_q;
    logic                   w_cnt_we;
    logic [ENTRY_BITS-1:0]  w_cnt_waddr;
    logic [PICK_BITS-1:0]   w_cnt_wdata;
    logic [ENTRY_BITS-1:0]  w_cnt_raddr;
    logic [PICK_BITS-1:0]   w_cnt_q;

    // misc combinational
    logic                   w_in_acc;
    logic                   w_out_free;
    logic                   w_finished;
    logic                   w_draw_ok;
    logic [CNT_BITS-1:0]    w_eff_loaded;
    logic [SUM_BITS-1:0]    w_eff_total;
    logic [PROD_BITS-1:0]   w_pfx_scaled;
    logic                   w_hit;
    logic [CNT_BITS-1:0]    w_nlo, w_nhi;
    logic [CNT_BITS:0]      w_mid_sum;
    logic [ENTRY_BITS-1:0]  w_sel_index;
    logic [PICK_BITS-1:0]   w_cnt_inc;
    logic                   n_search_upd;

    wis_ram #(.ADDR_BITS(ENTRY_BITS), .DATA_BITS(SUM_BITS)) u_pfx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_pfx_we),
        .i_wr_addr (w_pfx_waddr),
        .i_wr_data (w_pfx_wdata),
        .i_rd_addr (w_pfx_raddr),
        .o_rd_data (w_pfx_q)
    );

    wis_ram #(.ADDR_BITS(ENTRY_BITS), .DATA_BITS(PICK_BITS)) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_cnt_we),
        .i_wr_addr (w_cnt_waddr),
        .i_wr_data (w_cnt_wdata),
        .i_rd_addr (w_cnt_raddr),
        .o_rd_data (w_cnt_q)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_finished = r_closed && (r_accepted >= r_target);
    assign w_draw_ok  = r_closed && (r_loaded != '0) && !w_finished;

    // a load into a closed set starts a fresh set
    assign w_eff_loaded = r_closed ? '0 : r_loaded;
    assign w_eff_total  = r_closed ? '0 : r_total;

    // prefix * (2^RANDOM_BITS - 1) as shift and subtract
    assign w_pfx_scaled = {w_pfx_q, {RANDOM_BITS{1'b0}}} - {{RANDOM_BITS{1'b0}}, w_pfx_q};
    assign w_hit        = (r_prod <= w_pfx_scaled);
    assign w_nlo        = w_hit ? r_lo : ({1'b0, r_mid} + CNT_BITS'(1));
    assign w_nhi        = w_hit ? {1'b0, r_mid} : r_hi;
    assign w_mid_sum    = {1'b0, w_nlo} + {1'b0, w_nhi};
    // search ending past the last entry means no match: index 0
    assign w_sel_index  = (w_nlo == r_loaded) ? '0 : w_nlo[ENTRY_BITS-1:0];
    assign w_cnt_inc    = (w_cnt_q != PICK_MAX) ? (w_cnt_q + PICK_BITS'(1)) : w_cnt_q;

    // RAM addressing
    always_comb begin
        w_pfx_we    = 1'b0;
        w_pfx_waddr = w_eff_loaded[ENTRY_BITS-1:0];
        w_pfx_wdata = w_eff_total + SUM_BITS'(r_weight);
        w_cnt_we    = 1'b0;
        w_cnt_waddr = w_eff_loaded[ENTRY_BITS-1:0];
        w_cnt_wdata = '0;
        w_cnt_raddr = w_sel_index;
        w_pfx_raddr = r_loaded[CNT_BITS-1:1];
        case (r_state)
            S_DEC: begin
                if (r_func == FUNC_LOAD && !w_eff_loaded[CNT_BITS-1]) begin
                    w_pfx_we = 1'b1;
                    w_cnt_we = 1'b1;
                end
            end
            S_SRCH: begin
                w_pfx_raddr = w_mid_sum[CNT_BITS-1:1];
            end
            S_CNT: begin
                w_cnt_waddr = r_res_index;
                w_cnt_wdata = w_cnt_inc;
                w_cnt_we    = r_allow_rep || (w_cnt_q == '0);
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_loaded     = r_loaded;
        n_total      = r_total;
        n_accepted   = r_accepted;
        n_closed     = r_closed;
        n_res_index  = r_res_index;
        n_res_status = r_res_status;
        n_res_count  = r_res_count;
        n_search_upd = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_res_index  = '0;
                n_res_status = STAT_IGNORED;
                n_res_count  = '0;
                n_state      = S_DONE;
                if (r_func == FUNC_LOAD) begin
                    n_loaded = w_eff_loaded;
                    n_total  = w_eff_total;
                    if (r_closed) begin
                        n_accepted = '0;
                        n_closed   = 1'b0;
                    end
                    if (!w_eff_loaded[CNT_BITS-1]) begin
                        n_res_index  = w_eff_loaded[ENTRY_BITS-1:0];
                        n_res_status = STAT_STORED;
                        n_total      = w_pfx_wdata;
                        n_loaded     = w_eff_loaded + CNT_BITS'(1);
                    end
                    if (r_last) begin
                        n_closed = 1'b1;
                    end
                end else if (w_draw_ok) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                n_search_upd = 1'b1;
                if (w_nlo >= w_nhi) begin
                    n_res_index = w_sel_index;
                    n_state     = S_CNT;
                end
            end
            S_CNT: begin
                if (!r_allow_rep && w_cnt_q != '0) begin
                    n_res_status = STAT_REJECTED;
                    n_res_count  = w_cnt_q;
                end else begin
                    n_res_status = STAT_ACCEPTED;
                    n_res_count  = w_cnt_inc;
                    if (r_accepted != PICK_MAX) begin
                        n_accepted = r_accepted + PICK_BITS'(1);
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loaded    <= '0;
            r_total     <= '0;
            r_accepted  <= '0;
            r_closed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_loaded   <= n_loaded;
            r_total    <= n_total;
            r_accepted <= n_accepted;
            r_closed   <= n_closed;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= PICK_BITS'(1);
            r_allow_rep <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PICK_TARGET:  r_target    <= i_cfg_data[PICK_BITS-1:0];
                CFG_ALLOW_REPEAT: r_allow_rep <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_func   <= i_func;
            r_weight <= i_weight;
            r_last   <= i_last_weight;
            r_rand   <= i_random_value;
        end
        if (r_state == S_DEC) begin
            // random * total, compared against scaled prefix sums
            r_prod <= PROD_BITS'(r_rand) * PROD_BITS'(r_total);
            r_lo   <= '0;
            r_hi   <= r_loaded;
            r_mid  <= r_loaded[CNT_BITS-1:1];
        end else if (n_search_upd) begin
            r_lo  <= w_nlo;
            r_hi  <= w_nhi;
            r_mid <= w_mid_sum[CNT_BITS-1:1];
        end
        r_res_index  <= n_res_index;
        r_res_status <= n_res_status;
        r_res_count  <= n_res_count;
        if (r_state == S_DONE && w_out_free) begin
            r_out_index  <= r_res_index;
            r_out_status <= r_res_status;
            r_out_count  <= r_res_count;
            r_out_done   <= r_accepted;
            r_out_fin    <= w_finished;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_index      = r_out_index;
    assign o_status     = r_out_status;
    assign o_pick_count = r_out_count;
    assign o_picks_done = r_out_done;
    assign o_finished   = r_out_fin;

    // search window never empty or past the loaded entries
    `ASSERT_CLK(a_srch_window, i_clk, i_rst_n, (r_state == S_SRCH) |-> ((r_lo < r_hi) && (r_hi <= r_loaded)))
    // entry count never exceeds the store
    `ASSERT_NEVER(a_loaded_max, i_clk, i_rst_n, r_loaded > CNT_BITS'(MAX_ENTRIES))
    // an accepted pick always reports a nonzero count
    `ASSERT_NEVER(a_acc_count, i_clk, i_rst_n, r_out_valid && (r_out_status == STAT_ACCEPTED) && (r_out_count == '0))

endmodule

// ----- tb/sv/tb_weighted_index_sampler.sv -----
// Self-checking testbench for the weighted index sampler: load, draw and config traffic.
`timescale 1ns / 1ps

module tb_weighted_index_sampler;
    import wis_pkg::*;

    // Idle cycles with no accepted word on either channel before giving up.
    // Worst legit case is one sender gap plus a full draw plus a long receiver
    // stall; this leaves a wide margin.
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned RANDOM_WORDS = 950;

    // One result word as the block reports it.
    typedef struct {
        logic [ENTRY_BITS-1:0] index;
        logic [1:0]            status;
        logic [PICK_BITS-1:0]  pick_count;
        logic [PICK_BITS-1:0]  picks_done;
        logic                  finished;
    } t_pick_word;

    // Scoreboard: keeps its own copy of the sampler state, predicts one
    // result word per accepted input word and checks results in order.
    class t_pick_ledger;
        logic [SUM_BITS-1:0]  prefix_sum [MAX_ENTRIES];
        logic [PICK_BITS-1:0] times_picked [MAX_ENTRIES];
        int unsigned          entries;
        logic [SUM_BITS-1:0]  total;
        logic [PICK_BITS-1:0] accepted;
        bit                   closed;
        logic [PICK_BITS-1:0] target;
        bit                   repeat_ok;
        t_pick_word           expected_picks [$];
        int unsigned          failures;

        function new();
            entries   = 0;
            total     = '0;
            accepted  = '0;
            closed    = 1'b0;
            target    = PICK_BITS'(1);
            repeat_ok = 1'b0;
            failures  = 0;
        endfunction

        function bit set_done();
            return closed && (accepted >= target);
        endfunction

        // Accepted input word: advance the state and queue the expected result.
        function void note_word(logic func, logic [WEIGHT_BITS-1:0] w, logic last,
                                logic [RANDOM_BITS-1:0] rv);
            t_pick_word      r;
            longint unsigned lhs;
            longint unsigned scale;
            int unsigned     hit;
            int unsigned     k;
            r.index      = '0;
            r.status     = STAT_IGNORED;
            r.pick_count = '0;
            if (func == FUNC_LOAD) begin
                // a load after the set was closed opens a fresh set
                if (closed) begin
                    entries  = 0;
                    total    = '0;
                    accepted = '0;
                    closed   = 1'b0;
                end
                // full store drops the weight but the last flag still counts
                if (entries < MAX_ENTRIES) begin
                    r.index               = entries[ENTRY_BITS-1:0];
                    total                 = total + w;
                    prefix_sum[entries]   = total;
                    times_picked[entries] = '0;
                    entries++;
                    r.status = STAT_STORED;
                end
                if (last)
                    closed = 1'b1;
            end else if (closed && entries > 0 && !set_done()) begin
                // first entry with rv * total <= prefix * (2^RANDOM_BITS - 1);
                // falls back to entry 0 when nothing matches
                scale = (64'd1 << RANDOM_BITS) - 1;
                lhs   = 64'(rv) * 64'(total);
                hit   = 0;
                for (k = 0; k < entries; k++) begin
                    if (lhs <= 64'(prefix_sum[k]) * scale) begin
                        hit = k;
                        break;
                    end
                end
                r.index = hit[ENTRY_BITS-1:0];
                if (!repeat_ok && times_picked[hit] != 0) begin
                    r.status     = STAT_REJECTED;
                    r.pick_count = times_picked[hit];
                end else begin
                    if (times_picked[hit] != PICK_MAX)
                        times_picked[hit] = times_picked[hit] + 1'b1;
                    if (accepted != PICK_MAX)
                        accepted = accepted + 1'b1;
                    r.status     = STAT_ACCEPTED;
                    r.pick_count = times_picked[hit];
                end
            end
            r.picks_done = accepted;
            r.finished   = set_done();
            expected_picks.push_back(r);
        endfunction

        // Accepted result word: compare field by field with the oldest prediction.
        function void check_word(t_pick_word got);
            t_pick_word want;
            if (expected_picks.size() == 0) begin
                $error("result word with nothing expected: index %0d status %0d",
                       got.index, got.status);
                failures++;
                return;
            end
            want = expected_picks.pop_front();
            if (got.index !== want.index) begin
                $error("index: expected %0d, got %0d", want.index, got.index);
                failures++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
            if (got.pick_count !== want.pick_count) begin
                $error("pick_count: expected %0d, got %0d", want.pick_count, got.pick_count);
                failures++;
            end
            if (got.picks_done !== want.picks_done) begin
                $error("picks_done: expected %0d, got %0d", want.picks_done, got.picks_done);
                failures++;
            end
            if (got.finished !== want.finished) begin
                $error("finished: expected %0d, got %0d", want.finished, got.finished);
                failures++;
            end
        endfunction
    endclass

    // ---------------------------------------------------------------- DUT I/O
    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_in_valid     = 1'b0;
    logic                     o_in_ready;
    logic                     i_func         = FUNC_LOAD;
    logic [WEIGHT_BITS-1:0]   i_weight       = '0;
    logic                     i_last_weight  = 1'b0;
    logic [RANDOM_BITS-1:0]   i_random_value = '0;
    logic                     o_out_valid;
    logic                     i_out_ready    = 1'b0;
    logic [ENTRY_BITS-1:0]    o_index;
    logic [1:0]               o_status;
    logic [PICK_BITS-1:0]     o_pick_count;
    logic [PICK_BITS-1:0]     o_picks_done;
    logic                     o_finished;
    logic                     i_cfg_wr_en    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index    = CFG_PICK_TARGET;
    logic [CFG_DATA_BITS-1:0] i_cfg_data     = '0;

    t_pick_ledger ledger      = new();
    int unsigned  words_sent  = 0;
    int unsigned  burst_left  = 4;
    int unsigned  quiet_cycles = 0;
    int unsigned  mode_left   = 0;
    int unsigned  stall_mode  = 0;

    always #5 i_clk = ~i_clk;

    weighted_index_sampler u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_weight       (i_weight),
        .i_last_weight  (i_last_weight),
        .i_random_value (i_random_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_index        (o_index),
        .o_status       (o_status),
        .o_pick_count   (o_pick_count),
        .o_picks_done   (o_picks_done),
        .o_finished     (o_finished),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // ------------------------------------------------------------- receiver
    // Ready follows a mode that is redrawn when its random run length expires:
    // always ready, coin-flip ready, or mostly stalled.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(20, 120);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: begin
                i_out_ready <= 1'b1;
            end
            1: begin
                i_out_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_out_ready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // ------------------------------------------------- monitor and watchdog
    // Handshakes are sampled at the rising edge, before any NBA of this step.
    always @(posedge i_clk) begin
        t_pick_word got;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                ledger.note_word(i_func, i_weight, i_last_weight, i_random_value);
            if (o_out_valid && i_out_ready) begin
                got.index      = o_index;
                got.status     = o_status;
                got.pick_count = o_pick_count;
                got.picks_done = o_picks_done;
                got.finished   = o_finished;
                ledger.check_word(got);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // --------------------------------------------------------------- sender
    function automatic logic [WEIGHT_BITS-1:0] random_weight();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return WEIGHT_BITS'($urandom_range(1, 15));
            default: return WEIGHT_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [RANDOM_BITS-1:0] random_fraction();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return RANDOM_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // Present one input word and hold it until accepted. Bursts of random
    // length, sometimes long with no gaps, separated by random gaps.
    task automatic push_word(logic func, logic [WEIGHT_BITS-1:0] w, logic last,
                             logic [RANDOM_BITS-1:0] rv);
        i_func         <= func;
        i_weight       <= w;
        i_last_weight  <= last;
        i_random_value <= rv;
        i_in_valid     <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 8);
        end
    endtask

    // unused fields carry random bits so every input bit toggles
    task automatic load(logic [WEIGHT_BITS-1:0] w, logic last);
        push_word(FUNC_LOAD, w, last, RANDOM_BITS'($urandom_range(0, 65535)));
    endtask

    task automatic draw(logic [RANDOM_BITS-1:0] rv);
        push_word(FUNC_DRAW, WEIGHT_BITS'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)), rv);
    endtask

    // Stop sending and wait for every predicted word; the block is idle after.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (ledger.expected_picks.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // Both registers, back to back; only called while the block is idle.
    task automatic configure(logic [CFG_DATA_BITS-1:0] tgt, logic rep);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_PICK_TARGET;
        i_cfg_data  <= tgt;
        @(posedge i_clk);
        i_cfg_index <= CFG_ALLOW_REPEAT;
        i_cfg_data  <= {{(CFG_DATA_BITS-1){1'b0}}, rep};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        ledger.target    = tgt;
        ledger.repeat_ok = rep;
    endtask

    // One random set: mostly small, now and then larger; a few sets are left
    // open (draws ignored, next set keeps growing) and a few draws land mid-load.
    task automatic run_random_set();
        int unsigned          n;
        int unsigned          draws;
        int unsigned          k;
        logic [PICK_BITS-1:0] tgt;
        logic                 rep;
        bit                   close_it;
        tgt = ($urandom_range(0, 9) == 0) ? 11'd1024 : 11'($urandom_range(1, 12));
        rep = 1'($urandom_range(0, 1));
        configure(tgt, rep);
        n        = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        close_it = ($urandom_range(0, 7) != 0);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 11) == 0)
                draw(random_fraction());
            load(random_weight(), close_it && (k == n - 1));
        end
        draws = $urandom_range(2, 2 * n + 6);
        if (draws > 48)
            draws = 48;
        for (k = 0; k < draws; k++)
            draw(random_fraction());
        drain();
    endtask

    // -------------------------------------------------------------- stimulus
    initial begin
        int unsigned random_base;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings (target 1, no repeats). Draws before anything is
        // loaded and while the set is still open are ignored.
        draw(16'h0000);
        load(16'h0000, 1'b0);
        draw(16'hffff);
        load(16'hffff, 1'b1);
        draw(16'hffff);     // lands on the last entry with full prefix
        draw(16'h1234);     // target met: ignored
        drain();

        // New set over a closed one; repeats rejected, zero-weight entry never hit.
        configure(11'd3, 1'b0);
        load(16'd5, 1'b0);
        load(16'd0, 1'b0);
        load(16'd9, 1'b1);
        draw(16'h0000);
        draw(16'h0000);
        draw(16'hffff);
        draw(16'd30000);
        draw(16'd20000);
        drain();

        // Zero total: every compare holds, entry 0 wins.
        load(16'd0, 1'b0);
        load(16'd0, 1'b1);
        draw(16'ha5a5);
        draw(16'h5a5a);
        drain();

        // Target zero: set finished as soon as it closes.
        configure(11'd0, 1'b1);
        load(16'd1, 1'b1);
        draw(16'h8000);
        drain();

        random_base = words_sent;
        while (words_sent - random_base < RANDOM_WORDS)
            run_random_set();

        drain();
        repeat (20) @(posedge i_clk);
        if (ledger.failures == 0 && ledger.expected_picks.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
